// ===== rtl/core/ted_pkg.sv =====
// Package for the text encoding detector: encoding codes, byte-position codes,
// BOM byte constants and the UTF-8 lead byte decoder.
// No dependencies.
`default_nettype none

package ted_pkg;

	typedef enum logic [2:0] {
		ENC_UTF32_BE = 3'd0,
		ENC_UTF32_LE = 3'd1,
		ENC_UTF16_BE = 3'd2,
		ENC_UTF16_LE = 3'd3,
		ENC_UTF8     = 3'd4,
		ENC_LATIN1   = 3'd5
	} enc_t;

	// Byte position codes: 0..3 count bytes seen; the others record the fourth byte.
	localparam logic [2:0] POS_THREE    = 3'd3;
	localparam logic [2:0] POS_FOURTH_0 = 3'd4;
	localparam logic [2:0] POS_FOURTH_F = 3'd5;
	localparam logic [2:0] POS_FOURTH_X = 3'd6;

	localparam logic [7:0] BYTE_FE    = 8'hFE;
	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] BYTE_EF    = 8'hEF;
	localparam logic [7:0] BYTE_BB    = 8'hBB;
	localparam logic [7:0] BYTE_BF    = 8'hBF;
	localparam logic [7:0] BYTE_ONE   = 8'h01;
	localparam logic [7:0] CONT_LOW   = 8'h80;
	localparam logic [7:0] CONT_HIGH  = 8'hBF;

	localparam logic [2:0] BOM_LEN_NONE = 3'd0;
	localparam logic [2:0] BOM_LEN_U16  = 3'd2;
	localparam logic [2:0] BOM_LEN_U8   = 3'd3;
	localparam logic [2:0] BOM_LEN_U32  = 3'd4;

	// Number of continuation bytes a UTF-8 lead byte asks for.
	function automatic logic [2:0] lead_continuations(input logic [7:0] b);
		logic [2:0] n;
		if (b < 8'hC0)      n = 3'd0;
		else if (b < 8'hE0) n = 3'd1;
		else if (b < 8'hF0) n = 3'd2;
		else if (b < 8'hF8) n = 3'd3;
		else if (b < 8'hFC) n = 3'd4;
		else                n = 3'd5;
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_encoding_detector.sv =====
// Text encoding detector: BOM sniffing with a UTF-8 validity scan.
// Depends on ted_pkg.
//
// A result leaves the output register after its last item is accepted (input register,
// then result register); the input register holds a last item while an earlier result is unread.
// Throughput: one item per cycle if not stalled; the per-byte update is a single pass.
// Reset clears the scan state and both valid flags; state clears again after each buffer.
`default_nettype none

module text_encoding_detector (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      ted_pkg::enc_t     encoding_code,
	output      logic [2:0]        bom_length
);
	import ted_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	logic [7:0] head_q [3];
	logic [2:0] pos_q;
	logic [2:0] pend_q;
	logic       inv_q;
	logic       stop_q;

	logic [7:0] head_n [3];
	logic [2:0] pos_n;
	logic [2:0] pend_n;
	logic       inv_n;
	logic       stop_n;

	logic [7:0] bom [4];
	enc_t       enc_d;
	logic [2:0] len_d;
	logic       ok;

	logic       out_valid_q;
	enc_t       enc_q;
	logic [2:0] len_q;

	// The input stage moves on unless it holds a last item and a result still waits.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		pend_n = pend_q;
		inv_n  = inv_q;
		stop_n = stop_q;
		if (!stop_q && !inv_q) begin
			if (pend_q != 3'd0) begin
				if (byte_s1 < CONT_LOW || byte_s1 > CONT_HIGH) begin
					inv_n  = 1'b1;
					pend_n = 3'd0;
				end else begin
					pend_n = pend_q - 3'd1;
				end
			end else if (byte_s1 == 8'h00) begin
				stop_n = 1'b1;
			end else begin
				pend_n = lead_continuations(byte_s1);
			end
		end

		head_n = head_q;
		pos_n  = pos_q;
		if (pos_q < POS_THREE) begin
			head_n[pos_q[1:0]] = byte_s1;
			pos_n = pos_q + 3'd1;
		end else if (pos_q == POS_THREE) begin
			if (byte_s1 == 8'h00)        pos_n = POS_FOURTH_0;
			else if (byte_s1 == BYTE_FF) pos_n = POS_FOURTH_F;
			else                         pos_n = POS_FOURTH_X;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bom[i] = (3'(i) < pos_n) ? head_n[i] : 8'h00;
		end
		case (pos_n)
			POS_FOURTH_F: bom[3] = BYTE_FF;
			POS_FOURTH_X: bom[3] = BYTE_ONE;
			default:      bom[3] = 8'h00;
		endcase

		ok = !inv_n && (stop_n || pend_n == 3'd0);
		if (bom[0] == 8'h00 && bom[1] == 8'h00 && bom[2] == BYTE_FE && bom[3] == BYTE_FF) begin
			enc_d = ENC_UTF32_BE;
			len_d = BOM_LEN_U32;
		end else if (bom[0] == BYTE_FF && bom[1] == BYTE_FE && bom[2] == 8'h00
				&& bom[3] == 8'h00) begin
			enc_d = ENC_UTF32_LE;
			len_d = BOM_LEN_U32;
		end else if (bom[0] == BYTE_FE && bom[1] == BYTE_FF) begin
			enc_d = ENC_UTF16_BE;
			len_d = BOM_LEN_U16;
		end else if (bom[0] == BYTE_FF && bom[1] == BYTE_FE) begin
			enc_d = ENC_UTF16_LE;
			len_d = BOM_LEN_U16;
		end else if (bom[0] == BYTE_EF && bom[1] == BYTE_BB && bom[2] == BYTE_BF) begin
			enc_d = ENC_UTF8;
			len_d = BOM_LEN_U8;
		end else begin
			enc_d = ok ? ENC_UTF8 : ENC_LATIN1;
			len_d = BOM_LEN_NONE;
		end
	end

	// The buffer state returns to zero once its last item has been judged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) head_q[i] <= 8'h00;
			pos_q  <= 3'd0;
			pend_q <= 3'd0;
			inv_q  <= 1'b0;
			stop_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				for (int i = 0; i < 3; i++) head_q[i] <= 8'h00;
				pos_q  <= 3'd0;
				pend_q <= 3'd0;
				inv_q  <= 1'b0;
				stop_q <= 1'b0;
			end else begin
				head_q <= head_n;
				pos_q  <= pos_n;
				pend_q <= pend_n;
				inv_q  <= inv_n;
				stop_q <= stop_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			enc_q <= enc_d;
			len_q <= len_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign encoding_code = enc_q;
	assign bom_length    = len_q;

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && last_s1))
		else $error("result appeared without a last item");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid_q)
		else $error("input stalled without a waiting result");

	a_no_pend_after_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		inv_q |-> pend_q == 3'd0 && !stop_q)
		else $error("scan state inconsistent after invalid continuation");

	a_bom4_is_utf32: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && len_q == BOM_LEN_U32 |->
			enc_q == ENC_UTF32_BE || enc_q == ENC_UTF32_LE)
		else $error("four-byte BOM with non-UTF-32 code");

	a_latin1_no_bom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && enc_q == ENC_LATIN1 |-> len_q == BOM_LEN_NONE)
		else $error("latin1 result with BOM length");

endmodule

`default_nettype wire
